[rtl/core/skt_pkg.sv]
// skt_pkg: shared types, sizes and codes of the sorted key table
// used by skt_cell and sorted_key_table_core; depends on nothing
package skt_pkg;

	localparam int DEPTH    = 32;
	localparam int KEY_BITS = 32;
	localparam int TAG_BITS = 32;
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int POS_W    = 5;
	localparam int FILL_W   = 6;

	typedef logic signed [KEY_BITS-1:0] key_t;
	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_DUMP   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_DUP     = 3'd1,
		ST_DELETED = 3'd2,
		ST_ABSENT  = 3'd3,
		ST_FOUND   = 3'd4,
		ST_LISTED  = 3'd5,
		ST_EMPTY   = 3'd6,
		ST_FULL    = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE,
		OP_ROTATE
	} cell_op_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_DUMP
	} fsm_t;

	typedef struct packed {
		key_t key;
		tag_t first;
		tag_t second;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		logic     sample;
		key_t     cmp_key;
		entry_t   req;
	} cell_cmd_t;

endpackage

[rtl/core/skt_cell.sv]
// skt_cell: one table slot holding a key and two tags, with its compare flags
// shifts toward either neighbor or takes the request entry; uses skt_pkg
module skt_cell import skt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  logic      occupied,
	input  logic      left_less,
	input  entry_t    left_data,
	input  entry_t    right_data,
	output entry_t    data,
	output logic      less,
	output logic      match
);

	entry_t data_q;
	logic   less_q;
	logic   match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			less_q  <= 1'b0;
			match_q <= 1'b0;
		end else if (cmd.sample) begin
			less_q  <= occupied && (data_q.key < cmd.cmp_key);
			match_q <= occupied && (data_q.key == cmd.cmp_key);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INSERT: begin
				if (!less_q) begin
					data_q <= left_less ? cmd.req : left_data;
				end
			end
			OP_DELETE: begin
				if (!less_q) begin
					data_q <= right_data;
				end
			end
			OP_ROTATE: begin
				data_q <= right_data;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data  = data_q;
	assign less  = less_q;
	assign match = match_q;

endmodule

[rtl/core/sorted_key_table_core.sv]
// sorted_key_table_core: sorted key table built as a row of skt_cell slots
// with a small sequencer for requests and results; uses skt_pkg and skt_cell
//
// Usage:
//  - A request (mode, key, first_tag, second_tag) is taken at a clock edge
//    with start high and busy low. busy stays high while it is worked on.
//  - Every cell compares its key with the request key in the accept cycle;
//    the next cycle shifts the row in one step and forms the result.
//  - Insert, delete and lookup go through the accept cycle and then the
//    execute state. The result shows in the cycle after the execute cycle
//    with done high, while the next request may already be accepted.
//  - A dump rotates the whole row through slot 0, one slot a cycle, until
//    every slot has been through it; the live entries come out in order as
//    they pass slot 0, done high on each, last high on the final one. An
//    empty table gives one result with status empty.
//  - Results are shown for exactly one cycle; there is no back-pressure.
//  - Reset empties the table; slot contents are not cleared.
module sorted_key_table_core import skt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          mode,
	input  key_t                key,
	input  tag_t                first_tag,
	input  tag_t                second_tag,
	output logic                done,
	output logic [2:0]          status,
	output key_t                out_key,
	output tag_t                out_first,
	output tag_t                out_second,
	output logic [POS_W-1:0]    position,
	output logic [FILL_W-1:0]   fill,
	output logic                last
);

	fsm_t      state_q, state_nxt;
	mode_t     mode_q;
	entry_t    req_q;
	cnt_t      count_q, count_nxt;
	idx_t      dump_q;
	cell_cmd_t cmd;

	entry_t             cell_data [DEPTH];
	logic [DEPTH-1:0]   less_v;
	logic [DEPTH-1:0]   match_v;
	logic [DEPTH-1:0]   occ_v;
	logic [DEPTH-1:0]   bound_v;

	logic    accept;
	logic    hit;
	idx_t    hit_pos;
	idx_t    ins_pos;
	entry_t  hit_data;

	logic        res_vld;
	status_t     res_status;
	key_t        res_key;
	tag_t        res_first;
	tag_t        res_second;
	idx_t        res_pos;
	cnt_t        res_fill;
	logic        res_last;

	logic                done_q;
	status_t             status_q;
	key_t                key_q;
	tag_t                first_q;
	tag_t                second_q;
	logic [POS_W-1:0]    pos_q;
	logic [FILL_W-1:0]   fill_q;
	logic                last_q;

	assign busy   = (state_q != FSM_IDLE);
	assign accept = start && !busy;

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ_v[i] = (cnt_t'(i) < count_q);
		skt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.occupied  (occ_v[i]),
			.left_less ((i == 0) ? 1'b1 : less_v[(i == 0) ? 0 : i - 1]),
			.left_data ((i == 0) ? cmd.req : cell_data[(i == 0) ? 0 : i - 1]),
			.right_data(cell_data[(i == DEPTH - 1) ? 0 : i + 1]),
			.data      (cell_data[i]),
			.less      (less_v[i]),
			.match     (match_v[i])
		);
		assign bound_v[i] = !less_v[i] && ((i == 0) ? 1'b1 : less_v[(i == 0) ? 0 : i - 1]);
	end

	// position and payload of the hit, insertion point
	always_comb begin
		hit_pos  = '0;
		ins_pos  = '0;
		hit_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match_v[i]) begin
				hit_pos  = hit_pos | idx_t'(i);
				hit_data = hit_data | cell_data[i];
			end
			if (bound_v[i]) begin
				ins_pos = ins_pos | idx_t'(i);
			end
		end
	end

	assign hit = |match_v;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					if (mode_t'(mode) == MODE_DUMP && count_q != '0) begin
						state_nxt = FSM_DUMP;
					end else begin
						state_nxt = FSM_EXEC;
					end
				end
			end
			FSM_EXEC: begin
				state_nxt = FSM_IDLE;
			end
			FSM_DUMP: begin
				if (dump_q == idx_t'(DEPTH - 1)) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: begin
				state_nxt = FSM_IDLE;
			end
		endcase
	end

	// cell commands and result
	always_comb begin
		cmd.op      = OP_HOLD;
		cmd.sample  = accept;
		cmd.cmp_key = key;
		cmd.req     = req_q;
		count_nxt   = count_q;
		res_vld     = 1'b0;
		res_status  = ST_ABSENT;
		res_key     = req_q.key;
		res_first   = '0;
		res_second  = '0;
		res_pos     = '0;
		res_fill    = count_q;
		res_last    = 1'b1;
		case (state_q)
			FSM_EXEC: begin
				res_vld = 1'b1;
				case (mode_q)
					MODE_INSERT: begin
						if (hit) begin
							res_status = ST_DUP;
							res_pos    = hit_pos;
						end else if (count_q == cnt_t'(DEPTH)) begin
							res_status = ST_FULL;
						end else begin
							cmd.op     = OP_INSERT;
							count_nxt  = count_q + cnt_t'(1);
							res_status = ST_ADDED;
							res_pos    = ins_pos;
							res_fill   = count_nxt;
						end
					end
					MODE_DELETE: begin
						if (hit) begin
							cmd.op     = OP_DELETE;
							count_nxt  = count_q - cnt_t'(1);
							res_status = ST_DELETED;
							res_pos    = hit_pos;
							res_fill   = count_nxt;
						end
					end
					MODE_LOOKUP: begin
						if (hit) begin
							res_status = ST_FOUND;
							res_first  = hit_data.first;
							res_second = hit_data.second;
							res_pos    = hit_pos;
						end
					end
					default: begin
						res_status = ST_EMPTY;
						res_key    = '0;
						res_fill   = '0;
					end
				endcase
			end
			FSM_DUMP: begin
				cmd.op     = OP_ROTATE;
				res_vld    = (cnt_t'(dump_q) < count_q);
				res_status = ST_LISTED;
				res_key    = cell_data[0].key;
				res_first  = cell_data[0].first;
				res_second = cell_data[0].second;
				res_pos    = dump_q;
				res_last   = (cnt_t'(dump_q) == count_q - cnt_t'(1));
			end
			default: begin
				res_vld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
			dump_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			done_q  <= res_vld;
			if (accept) begin
				dump_q <= '0;
			end else if (state_q == FSM_DUMP) begin
				dump_q <= dump_q + idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q        <= mode_t'(mode);
			req_q.key     <= key;
			req_q.first   <= first_tag;
			req_q.second  <= second_tag;
		end
		status_q <= res_status;
		key_q    <= res_key;
		first_q  <= res_first;
		second_q <= res_second;
		pos_q    <= POS_W'(res_pos);
		fill_q   <= FILL_W'(res_fill);
		last_q   <= res_last;
	end

	assign done       = done_q;
	assign status     = status_q;
	assign out_key    = key_q;
	assign out_first  = first_q;
	assign out_second = second_q;
	assign position   = pos_q;
	assign fill       = fill_q;
	assign last       = last_q;

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without work in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(DEPTH))
		else $error("entry count beyond capacity");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_v))
		else $error("key matched in more than one slot");

	a_sorted_row: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bound_v))
		else $error("compare flags not ordered along the row");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request taken without going busy");

endmodule
